// ----- design/hrp_pkg.sv -----
package hrp_pkg;

    localparam int MAX_LINE_DEF    = 250;
    localparam int LENGTH_BITS_DEF = 31;

    localparam int BYTE_W   = 8;
    localparam int FIELD_W  = 31;
    localparam int STATUS_W = 4;
    localparam int TICK_W   = 16;

    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_BUF_SIZE = 2'd1;
    localparam logic [1:0] CFG_TRUNCATE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 4'd2;
    localparam logic [STATUS_W-1:0] ST_SERVER    = 4'd3;
    localparam logic [STATUS_W-1:0] ST_CLIENT    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_REDIRECT  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_PARSE     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_BUF_SMALL = 4'd8;

    localparam int CODE_OK        = 200;
    localparam int CODE_NOT_FOUND = 404;
    localparam int CODE_SERVER    = 500;
    localparam int CODE_CLIENT    = 400;
    localparam int CODE_REDIRECT  = 300;

    localparam int HTTP_LEN = 5;
    localparam int CL_LEN   = 16;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;

    typedef enum logic [6:0] {
        PM_START     = 7'b0000001,
        PM_HTTP_PART = 7'b0000010,
        PM_CL_PART   = 7'b0000100,
        PM_HTTP_FULL = 7'b0001000,
        PM_CL_FULL   = 7'b0010000,
        PM_NONE      = 7'b0100000,
        PM_CR_ONLY   = 7'b1000000
    } prefix_t;

    typedef enum logic [3:0] {
        FP_SEEK   = 4'b0001,
        FP_SPACE  = 4'b0010,
        FP_DIGITS = 4'b0100,
        FP_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [BYTE_W-1:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic                body_valid;
        logic [BYTE_W-1:0]   body_byte;
        logic [FIELD_W-1:0]  body_offset;
        logic                length_valid;
        logic [FIELD_W-1:0]  content_length;
        logic                done_res;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    typedef struct packed {
        logic [TICK_W-1:0]  timeout_ticks;
        logic [FIELD_W-1:0] buffer_size;
        logic               truncate_ok;
    } cfg_t;

    function automatic logic [BYTE_W-1:0] http_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0:    c = "H";
            3'd1:    c = "T";
            3'd2:    c = "T";
            3'd3:    c = "P";
            3'd4:    c = "/";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] cl_char(input logic [3:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = " ";
        endcase
        return c;
    endfunction

endpackage

// ----- design/hrp_cfg.sv -----
module hrp_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [hrp_pkg::FIELD_W-1:0] cfg_data,
    output hrp_pkg::cfg_t              cfg
);
    import hrp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TICK_W'(1000);
            cfg_reg.buffer_size   <= FIELD_W'(65536);
            cfg_reg.truncate_ok   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TIMEOUT:  cfg_reg.timeout_ticks <= cfg_data[TICK_W-1:0];
                CFG_BUF_SIZE: cfg_reg.buffer_size   <= cfg_data;
                CFG_TRUNCATE: cfg_reg.truncate_ok   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/hrp_core.sv -----
module hrp_core
#(
    parameter int MAX_LINE    = hrp_pkg::MAX_LINE_DEF,
    parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  hrp_pkg::cfg_t      cfg,
    input  logic               accept,
    input  hrp_pkg::in_word_t  in_data,
    output hrp_pkg::out_word_t result
);
    import hrp_pkg::*;

    localparam int LPW = $clog2(MAX_LINE + 1);
    localparam int LB  = LENGTH_BITS;
    localparam int CW  = 33;

    logic              active_reg, active_next;
    logic              in_body_reg, in_body_next;
    logic [LPW-1:0]    line_position_reg, line_position_next;
    prefix_t           prefix_match_reg, prefix_match_next;
    phase_t            field_phase_reg, field_phase_next;
    logic [LB-1:0]     number_acc_reg, number_acc_next;
    logic [LB-1:0]     length_value_reg, length_value_next;
    logic              length_seen_reg, length_seen_next;
    logic [LB-1:0]     body_count_reg, body_count_next;
    logic [TICK_W-1:0] timeout_left_reg, timeout_left_next;

    logic [BYTE_W-1:0] b;
    logic              digit;
    logic [3:0]        d;
    logic [LB+3:0]     acc_prod;
    logic              blank;
    logic [CW-1:0]     len_x;
    logic [CW-1:0]     bs_x;
    logic              done;
    logic [STATUS_W-1:0] st;

    assign b        = in_data.rx_byte;
    assign digit    = (b >= CH_ZERO) && (b <= CH_NINE);
    assign d        = 4'(b - CH_ZERO);
    assign acc_prod = {1'b0, number_acc_reg, 3'b000} + {3'b000, number_acc_reg, 1'b0}
                      + (LB+4)'(d);
    assign blank    = (line_position_reg == '0) || (prefix_match_reg == PM_CR_ONLY);
    assign len_x    = CW'(number_acc_reg);
    assign bs_x     = (cfg.buffer_size == '0) ? CW'(1) : CW'(cfg.buffer_size);

    always_comb
    begin
        active_next        = active_reg;
        in_body_next       = in_body_reg;
        line_position_next = line_position_reg;
        prefix_match_next  = prefix_match_reg;
        field_phase_next   = field_phase_reg;
        number_acc_next    = number_acc_reg;
        length_value_next  = length_value_reg;
        length_seen_next   = length_seen_reg;
        body_count_next    = body_count_reg;
        timeout_left_next  = timeout_left_reg;
        done               = 1'b0;
        st                 = ST_OK;
        result             = '0;

        if (accept)
        begin
            case (in_data.action)
                ACT_RESTART:
                begin
                    active_next        = 1'b1;
                    in_body_next       = 1'b0;
                    line_position_next = '0;
                    prefix_match_next  = PM_START;
                    field_phase_next   = FP_SEEK;
                    number_acc_next    = '0;
                    length_value_next  = '0;
                    length_seen_next   = 1'b0;
                    body_count_next    = '0;
                    timeout_left_next  = cfg.timeout_ticks;
                end
                ACT_TICK:
                begin
                    if (active_reg)
                    begin
                        if (timeout_left_reg == '0)
                        begin
                            done = 1'b1;
                            st   = ST_TIMEOUT;
                        end
                        else
                        begin
                            timeout_left_next = timeout_left_reg - 1'b1;
                        end
                    end
                end
                ACT_BYTE:
                begin
                    if (active_reg)
                    begin
                        timeout_left_next = cfg.timeout_ticks;
                        if (in_body_reg)
                        begin
                            // body byte, last one also closes the reply
                            if (body_count_reg < length_value_reg)
                            begin
                                result.body_valid  = 1'b1;
                                result.body_byte   = b;
                                result.body_offset = FIELD_W'(body_count_reg);
                                body_count_next    = body_count_reg + 1'b1;
                            end
                            if (body_count_next >= length_value_reg)
                            begin
                                done = 1'b1;
                                st   = ST_OK;
                            end
                        end
                        else if (b == CH_LF)
                        begin
                            if (blank)
                            begin
                                if (!length_seen_reg)
                                begin
                                    done = 1'b1;
                                    st   = ST_PARSE;
                                end
                                else
                                begin
                                    in_body_next    = 1'b1;
                                    body_count_next = '0;
                                    if (length_value_reg == '0)
                                    begin
                                        done = 1'b1;
                                        st   = ST_OK;
                                    end
                                end
                            end
                            else if (prefix_match_reg == PM_HTTP_FULL)
                            begin
                                if (field_phase_reg == FP_SEEK)
                                begin
                                    done = 1'b1;
                                    st   = ST_NOT_FOUND;
                                end
                                else if (number_acc_reg != LB'(CODE_OK))
                                begin
                                    done = 1'b1;
                                    if (number_acc_reg >= LB'(CODE_SERVER))
                                        st = ST_SERVER;
                                    else if (number_acc_reg == LB'(CODE_NOT_FOUND))
                                        st = ST_NOT_FOUND;
                                    else if (number_acc_reg >= LB'(CODE_CLIENT))
                                        st = ST_CLIENT;
                                    else if (number_acc_reg >= LB'(CODE_REDIRECT))
                                        st = ST_REDIRECT;
                                    else
                                        st = ST_UNKNOWN;
                                end
                            end
                            else if (prefix_match_reg == PM_CL_FULL && !length_seen_reg
                                     && number_acc_reg != '0)
                            begin
                                if (!cfg.truncate_ok && len_x > bs_x)
                                begin
                                    done = 1'b1;
                                    st   = ST_BUF_SMALL;
                                end
                                else
                                begin
                                    if (cfg.truncate_ok && len_x >= bs_x)
                                        length_value_next = LB'(bs_x - 1'b1);
                                    else
                                        length_value_next = number_acc_reg;
                                    length_seen_next = 1'b1;
                                end
                            end
                            line_position_next = '0;
                            prefix_match_next  = PM_START;
                            field_phase_next   = FP_SEEK;
                            number_acc_next    = '0;
                        end
                        else if (b != '0 && line_position_reg < LPW'(MAX_LINE))
                        begin
                            line_position_next = line_position_reg + 1'b1;
                            case (prefix_match_reg)
                                PM_START:
                                begin
                                    if (b == CH_H)
                                        prefix_match_next = PM_HTTP_PART;
                                    else if (b == CH_C)
                                        prefix_match_next = PM_CL_PART;
                                    else if (b == CH_CR)
                                        prefix_match_next = PM_CR_ONLY;
                                    else
                                        prefix_match_next = PM_NONE;
                                end
                                PM_HTTP_PART:
                                begin
                                    if (line_position_reg < LPW'(HTTP_LEN)
                                        && b == http_char(line_position_reg[2:0]))
                                    begin
                                        if (line_position_reg == LPW'(HTTP_LEN - 1))
                                        begin
                                            prefix_match_next = PM_HTTP_FULL;
                                            field_phase_next  = FP_SEEK;
                                        end
                                    end
                                    else
                                    begin
                                        prefix_match_next = PM_NONE;
                                    end
                                end
                                PM_CL_PART:
                                begin
                                    if (line_position_reg < LPW'(CL_LEN)
                                        && b == cl_char(line_position_reg[3:0]))
                                    begin
                                        if (line_position_reg == LPW'(CL_LEN - 1))
                                        begin
                                            prefix_match_next = PM_CL_FULL;
                                            field_phase_next  = FP_SPACE;
                                        end
                                    end
                                    else
                                    begin
                                        prefix_match_next = PM_NONE;
                                    end
                                end
                                PM_HTTP_FULL, PM_CL_FULL:
                                begin
                                    // number field after the prefix
                                    case (field_phase_reg)
                                        FP_SEEK:
                                        begin
                                            if (b == CH_SPACE)
                                                field_phase_next = FP_SPACE;
                                        end
                                        FP_SPACE:
                                        begin
                                            if (digit)
                                            begin
                                                number_acc_next  = LB'(d);
                                                field_phase_next = FP_DIGITS;
                                            end
                                            else if (b != CH_SPACE)
                                            begin
                                                field_phase_next = FP_DONE;
                                            end
                                        end
                                        FP_DIGITS:
                                        begin
                                            if (digit)
                                            begin
                                                if (acc_prod[LB+3:LB] != '0)
                                                    number_acc_next = '1;
                                                else
                                                    number_acc_next = acc_prod[LB-1:0];
                                            end
                                            else
                                            begin
                                                field_phase_next = FP_DONE;
                                            end
                                        end
                                        default: ;
                                    endcase
                                end
                                PM_CR_ONLY:
                                begin
                                    prefix_match_next = PM_NONE;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                default: ;
            endcase

            if (done)
                active_next = 1'b0;
        end

        result.length_valid   = length_seen_next;
        result.content_length = length_seen_next ? FIELD_W'(length_value_next) : '0;
        result.done_res       = done;
        result.status         = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            in_body_reg       <= 1'b0;
            line_position_reg <= '0;
            prefix_match_reg  <= PM_START;
            field_phase_reg   <= FP_SEEK;
            number_acc_reg    <= '0;
            length_value_reg  <= '0;
            length_seen_reg   <= 1'b0;
            body_count_reg    <= '0;
            timeout_left_reg  <= '0;
        end
        else
        begin
            active_reg        <= active_next;
            in_body_reg       <= in_body_next;
            line_position_reg <= line_position_next;
            prefix_match_reg  <= prefix_match_next;
            field_phase_reg   <= field_phase_next;
            number_acc_reg    <= number_acc_next;
            length_value_reg  <= length_value_next;
            length_seen_reg   <= length_seen_next;
            body_count_reg    <= body_count_next;
            timeout_left_reg  <= timeout_left_next;
        end
    end

    a_body_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> length_seen_reg)
        else $error("body phase without accepted length");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> body_count_reg <= length_value_reg)
        else $error("body count passed length");

    a_line_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        line_position_reg <= LPW'(MAX_LINE))
        else $error("line position passed limit");

endmodule

// ----- design/hrp_outreg.sv -----
module hrp_outreg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                accept,
    input  hrp_pkg::out_word_t  result,
    output logic                out_valid,
    input  logic                out_stall,
    output hrp_pkg::out_word_t  out_data
);
    import hrp_pkg::*;

    logic      out_valid_reg;
    out_word_t out_data_reg;

    // the slot frees in the same cycle its word is taken
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_status_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != ST_OK |-> out_data_reg.done_res)
        else $error("error status without done");

    a_body_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.body_valid |-> out_data_reg.length_valid)
        else $error("body word without length");

endmodule

// ----- design/http_response_header_parser.sv -----
// an accepted input word's result word is registered and shows in the cycle after it is accepted
// throughput: one word per cycle while out_stall is low, set by the single result register
// the next word is taken in the cycle its predecessor's result is taken
// reset: asynchronous, registers but the result data to defaults, parser idle until a restart
module http_response_header_parser
#(
    parameter int MAX_LINE    = hrp_pkg::MAX_LINE_DEF,
    parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [hrp_pkg::FIELD_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  hrp_pkg::in_word_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output hrp_pkg::out_word_t          out_data
);
    import hrp_pkg::*;

    cfg_t      cfg;
    logic      accept;
    out_word_t result;

    hrp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hrp_core
    #(
        .MAX_LINE    (MAX_LINE),
        .LENGTH_BITS (LENGTH_BITS)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .in_data (in_data),
        .result  (result)
    );

    hrp_outreg u_outreg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .accept    (accept),
        .result    (result),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
